// ===== design/permutation_compose_inverse_parity_assert.svh =====
// Assertion macros for the permutation store.
// Used by permutation_compose_inverse_parity.sv; no other dependencies.
`ifndef PERMUTATION_COMPOSE_INVERSE_PARITY_ASSERT_SVH
`define PERMUTATION_COMPOSE_INVERSE_PARITY_ASSERT_SVH

// Same-cycle implication
`define PCIP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcip: same-cycle check failed");

// Next-cycle implication
`define PCIP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcip: next-cycle check failed");

`endif

// ===== design/pcip_pkg.sv =====
// Shared constants, codes and inter-module structs for the permutation store.
// No dependencies; used by pcip_mem, pcip_check and the top level.
`default_nettype none

package pcip_pkg;

  // default permutation order limit
  localparam int unsigned PCIP_ORDER_LIMIT = 16;

  // fixed field widths
  localparam int unsigned SYM_W  = 6;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned MAW    = SYM_W;  // address/data field width in mem_ctl_t

  // command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPOSE = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERFLOW = 3'd1,
    ST_RANGE    = 3'd2,
    ST_DUP      = 3'd3,
    ST_MISSING  = 3'd4,
    ST_MISMATCH = 3'd5
  } status_t;

  // memory port controls from the sequencer
  typedef struct packed {
    logic           buf_we;
    logic [MAW-1:0] buf_waddr;
    logic [MAW-1:0] buf_wdata;
    logic           buf_re;
    logic [MAW-1:0] buf_raddr;
    logic           perm_we;
    logic [MAW-1:0] perm_waddr;
    logic [MAW-1:0] perm_wdata;
    logic           perm_re;
    logic [MAW-1:0] perm_raddr;
    logic           inv_we;
    logic [MAW-1:0] inv_waddr;
    logic [MAW-1:0] inv_wdata;
    logic           inv_re;
    logic [MAW-1:0] inv_raddr;
  } mem_ctl_t;

  // controls into the element check unit
  typedef struct packed {
    logic clr;
    logic en;
  } chk_ctl_t;

  // flags from the element check unit
  typedef struct packed {
    logic range_bad;
    logic dup;
    logic missing;
    logic parity;
  } chk_res_t;

endpackage

`default_nettype wire

// ===== design/pcip_mem.sv =====
// Incoming buffer, permutation store and inverse store, one write and one
// registered read port each. Depends on pcip_pkg.
`default_nettype none

module pcip_mem #(
  parameter int unsigned ORDER_LIMIT = pcip_pkg::PCIP_ORDER_LIMIT,
  localparam int unsigned AW = $clog2(ORDER_LIMIT)
) (
  input  wire logic                       clk,
  input  wire pcip_pkg::mem_ctl_t         ctl,
  output logic [pcip_pkg::SYM_W-1:0]      buf_rdata,
  output logic [AW-1:0]                   perm_rdata,
  output logic [AW-1:0]                   inv_rdata
);
  import pcip_pkg::*;

  logic [SYM_W-1:0] buf_mem  [ORDER_LIMIT];
  logic [AW-1:0]    perm_mem [ORDER_LIMIT];
  logic [AW-1:0]    inv_mem  [ORDER_LIMIT];

  logic [SYM_W-1:0] buf_rdata_r;
  logic [AW-1:0]    perm_rdata_r;
  logic [AW-1:0]    inv_rdata_r;

  // incoming symbols, full width so range checks see the raw value
  always_ff @(posedge clk) begin
    if (ctl.buf_we) begin
      buf_mem[ctl.buf_waddr[AW-1:0]] <= ctl.buf_wdata;
    end
    if (ctl.buf_re) begin
      buf_rdata_r <= buf_mem[ctl.buf_raddr[AW-1:0]];
    end
  end

  // stored permutation
  always_ff @(posedge clk) begin
    if (ctl.perm_we) begin
      perm_mem[ctl.perm_waddr[AW-1:0]] <= ctl.perm_wdata[AW-1:0];
    end
    if (ctl.perm_re) begin
      perm_rdata_r <= perm_mem[ctl.perm_raddr[AW-1:0]];
    end
  end

  // inverse permutation
  always_ff @(posedge clk) begin
    if (ctl.inv_we) begin
      inv_mem[ctl.inv_waddr[AW-1:0]] <= ctl.inv_wdata[AW-1:0];
    end
    if (ctl.inv_re) begin
      inv_rdata_r <= inv_mem[ctl.inv_raddr[AW-1:0]];
    end
  end

  assign buf_rdata  = buf_rdata_r;
  assign perm_rdata = perm_rdata_r;
  assign inv_rdata  = inv_rdata_r;

endmodule

`default_nettype wire

// ===== design/pcip_check.sv =====
// Element check unit: range, duplicate and missing tests with a seen map,
// plus running inversion parity of the incoming sequence. Depends on pcip_pkg.
`default_nettype none

module pcip_check #(
  parameter int unsigned ORDER_LIMIT = pcip_pkg::PCIP_ORDER_LIMIT,
  localparam int unsigned CW = $clog2(ORDER_LIMIT + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pcip_pkg::chk_ctl_t         ctl,
  input  wire logic [pcip_pkg::SYM_W-1:0] value,
  input  wire logic [CW-1:0]              order,
  output pcip_pkg::chk_res_t              res
);
  import pcip_pkg::*;

  localparam int unsigned AW   = $clog2(ORDER_LIMIT);
  localparam int unsigned CMPW = SYM_W + 1;

  logic [ORDER_LIMIT-1:0] seen_r, seen_nxt;
  logic                   par_r, par_nxt;
  logic [ORDER_LIMIT-1:0] hit, gt, low;

  // per-slot compares against the current value and the order
  always_comb begin
    for (int k = 0; k < ORDER_LIMIT; k++) begin
      hit[k] = (CMPW'(k) == CMPW'(value));
      gt[k]  = (CMPW'(k) >  CMPW'(value));
      low[k] = (CMPW'(k) <  CMPW'(order));
    end
  end

  // flags
  always_comb begin
    res.range_bad = (CMPW'(value) >= CMPW'(order));
    res.dup       = !res.range_bad && seen_r[value[AW-1:0]];
    res.missing   = |(low & ~seen_r);
    res.parity    = par_r;
  end

  // seen map and parity: each new value adds the count of larger values
  // already seen
  always_comb begin
    seen_nxt = seen_r;
    par_nxt  = par_r;
    if (ctl.clr) begin
      seen_nxt = '0;
      par_nxt  = 1'b0;
    end else if (ctl.en && !res.range_bad && !res.dup) begin
      seen_nxt = seen_r | hit;
      par_nxt  = par_r ^ (^(seen_r & gt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      par_r  <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      par_r  <= par_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/permutation_compose_inverse_parity.sv =====
// Top level of the permutation store: sequencer, counters and output register.
// Depends on pcip_pkg, pcip_mem, pcip_check and the assertion macro header.
`default_nettype none
`include "permutation_compose_inverse_parity_assert.svh"

// Symbols are taken one per cycle into the incoming buffer while in_stall
// is low. The item with last set starts the judgement and in_stall stays
// high until the final result of the run is in the output register. The
// run scans the buffered symbols one element per cycle through the check
// unit over the buffer's single read port, judges, composes (compose only,
// buffer read then store read), copies into the permutation and inverse
// stores, and then fetches each result and loads it into the output
// register, where out_stall can hold it. An error run moves to S_ERR
// once the error is found, or on the closing item for an overflow, and
// loads its single result when the output register is free. A compose's
// permutation parity is the stored parity xor the incoming sequence's.
module permutation_compose_inverse_parity #(
  parameter int unsigned ORDER_LIMIT = pcip_pkg::PCIP_ORDER_LIMIT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_command,
  input  wire logic [pcip_pkg::SYM_W-1:0]  in_symbol,
  input  wire logic                        in_last,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [pcip_pkg::POS_W-1:0]       out_position,
  output logic [pcip_pkg::POS_W-1:0]       out_entry_value,
  output logic [pcip_pkg::POS_W-1:0]       out_inverse_value,
  output logic                             out_odd,
  output logic [pcip_pkg::STAT_W-1:0]      out_status,
  output logic                             out_final_res
);
  import pcip_pkg::*;

  localparam int unsigned CW = $clog2(ORDER_LIMIT + 1);
  localparam int unsigned AW = $clog2(ORDER_LIMIT);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CHECK   = 8'b0000_0010,
    S_JUDGE   = 8'b0000_0100,
    S_COMPOSE = 8'b0000_1000,
    S_COPY    = 8'b0001_0000,
    S_EMIT_RD = 8'b0010_0000,
    S_EMIT_LD = 8'b0100_0000,
    S_ERR     = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic            cmd_r, cmd_nxt;
  logic [CW-1:0]   order_r, order_nxt;
  logic            par_store_r, par_store_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            dv1_r, dv1_nxt;
  logic            dv2_r, dv2_nxt;
  logic [CW-1:0]   i1_r, i1_nxt;
  logic [CW-1:0]   i2_r, i2_nxt;
  status_t         stat_r, stat_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [POS_W-1:0]  out_entry_r, out_entry_nxt;
  logic [POS_W-1:0]  out_inv_r, out_inv_nxt;
  logic              out_odd_r, out_odd_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_final_r, out_final_nxt;

  mem_ctl_t          mctl;
  chk_ctl_t          cctl;
  chk_res_t          cres;
  logic [SYM_W-1:0]  buf_rdata;
  logic [AW-1:0]     perm_rdata;
  logic [AW-1:0]     inv_rdata;

  logic              in_acc;
  logic              out_free;
  logic              issue;
  logic              fin;
  logic [CW-1:0]     n_m1;

  pcip_mem #(.ORDER_LIMIT(ORDER_LIMIT)) u_mem (
    .clk        (clk),
    .ctl        (mctl),
    .buf_rdata  (buf_rdata),
    .perm_rdata (perm_rdata),
    .inv_rdata  (inv_rdata)
  );

  pcip_check #(.ORDER_LIMIT(ORDER_LIMIT)) u_check (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .value (buf_rdata),
    .order (cnt_r),
    .res   (cres)
  );

  // handshake helpers
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign issue    = (idx_r < cnt_r);
  assign n_m1     = cnt_r - CW'(1);
  assign fin      = (idx_r == n_m1);

  // check unit control: cleared while collecting, fed during the scan
  always_comb begin
    cctl.clr = (state_r == S_IDLE);
    cctl.en  = (state_r == S_CHECK) && dv1_r;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    cmd_nxt        = cmd_r;
    order_nxt      = order_r;
    par_store_nxt  = par_store_r;
    idx_nxt        = idx_r;
    dv1_nxt        = 1'b0;
    dv2_nxt        = 1'b0;
    i1_nxt         = i1_r;
    i2_nxt         = i2_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_pos_nxt    = out_pos_r;
    out_entry_nxt  = out_entry_r;
    out_inv_nxt    = out_inv_r;
    out_odd_nxt    = out_odd_r;
    out_status_nxt = out_status_r;
    out_final_nxt  = out_final_r;
    mctl           = '0;

    case (state_r)
      // collect symbols, drop and flag any beyond the limit
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_r < CW'(ORDER_LIMIT)) begin
            mctl.buf_we    = 1'b1;
            mctl.buf_waddr = MAW'(cnt_r[AW-1:0]);
            mctl.buf_wdata = in_symbol;
            cnt_nxt        = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            cmd_nxt = in_command;
            idx_nxt = '0;
            if (ovf_nxt) begin
              stat_nxt  = ST_OVERFLOW;
              state_nxt = S_ERR;
            end else begin
              state_nxt = S_CHECK;
            end
          end
        end
      end

      // one element per cycle: read ahead, judge the previous read
      S_CHECK: begin
        if (issue) begin
          mctl.buf_re    = 1'b1;
          mctl.buf_raddr = MAW'(idx_r[AW-1:0]);
          idx_nxt        = idx_r + CW'(1);
          dv1_nxt        = 1'b1;
          i1_nxt         = idx_r;
        end
        if (dv1_r) begin
          if (cres.range_bad) begin
            stat_nxt  = ST_RANGE;
            state_nxt = S_ERR;
            dv1_nxt   = 1'b0;
          end else if (cres.dup) begin
            stat_nxt  = ST_DUP;
            state_nxt = S_ERR;
            dv1_nxt   = 1'b0;
          end else if (i1_r == n_m1) begin
            state_nxt = S_JUDGE;
            dv1_nxt   = 1'b0;
          end
        end
      end

      // missing values, then order mismatch for compose
      S_JUDGE: begin
        idx_nxt = '0;
        if (cres.missing) begin
          stat_nxt  = ST_MISSING;
          state_nxt = S_ERR;
        end else if (cmd_r == CMD_COMPOSE && cnt_r != order_r) begin
          stat_nxt  = ST_MISMATCH;
          state_nxt = S_ERR;
        end else if (cmd_r == CMD_COMPOSE) begin
          state_nxt = S_COMPOSE;
        end else begin
          state_nxt = S_COPY;
        end
      end

      // buffer[i] <= perm[buffer[i]], three-stage pipeline
      S_COMPOSE: begin
        if (issue) begin
          mctl.buf_re    = 1'b1;
          mctl.buf_raddr = MAW'(idx_r[AW-1:0]);
          idx_nxt        = idx_r + CW'(1);
          dv1_nxt        = 1'b1;
          i1_nxt         = idx_r;
        end
        if (dv1_r) begin
          mctl.perm_re    = 1'b1;
          mctl.perm_raddr = MAW'(buf_rdata[AW-1:0]);
          dv2_nxt         = 1'b1;
          i2_nxt          = i1_r;
        end
        if (dv2_r) begin
          mctl.buf_we    = 1'b1;
          mctl.buf_waddr = MAW'(i2_r[AW-1:0]);
          mctl.buf_wdata = MAW'(perm_rdata);
          if (i2_r == n_m1) begin
            state_nxt = S_COPY;
            idx_nxt   = '0;
            dv1_nxt   = 1'b0;
            dv2_nxt   = 1'b0;
          end
        end
      end

      // write the new permutation and its inverse
      S_COPY: begin
        if (issue) begin
          mctl.buf_re    = 1'b1;
          mctl.buf_raddr = MAW'(idx_r[AW-1:0]);
          idx_nxt        = idx_r + CW'(1);
          dv1_nxt        = 1'b1;
          i1_nxt         = idx_r;
        end
        if (dv1_r) begin
          mctl.perm_we    = 1'b1;
          mctl.perm_waddr = MAW'(i1_r[AW-1:0]);
          mctl.perm_wdata = MAW'(buf_rdata[AW-1:0]);
          mctl.inv_we     = 1'b1;
          mctl.inv_waddr  = MAW'(buf_rdata[AW-1:0]);
          mctl.inv_wdata  = MAW'(i1_r[AW-1:0]);
          if (i1_r == n_m1) begin
            order_nxt     = cnt_r;
            par_store_nxt = (cmd_r == CMD_COMPOSE) ? (par_store_r ^ cres.parity)
                                                   : cres.parity;
            state_nxt     = S_EMIT_RD;
            idx_nxt       = '0;
            dv1_nxt       = 1'b0;
          end
        end
      end

      // fetch entry and inverse for one position
      S_EMIT_RD: begin
        mctl.perm_re    = 1'b1;
        mctl.perm_raddr = MAW'(idx_r[AW-1:0]);
        mctl.inv_re     = 1'b1;
        mctl.inv_raddr  = MAW'(idx_r[AW-1:0]);
        state_nxt       = S_EMIT_LD;
      end

      // hand the item to the output register once it is free
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_pos_nxt    = POS_W'(idx_r);
          out_entry_nxt  = POS_W'(perm_rdata);
          out_inv_nxt    = POS_W'(inv_rdata);
          out_odd_nxt    = fin && par_store_r;
          out_status_nxt = ST_OK;
          out_final_nxt  = fin;
          if (fin) begin
            state_nxt = S_IDLE;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      // single status item, store untouched
      S_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_pos_nxt    = '0;
          out_entry_nxt  = '0;
          out_inv_nxt    = '0;
          out_odd_nxt    = 1'b0;
          out_status_nxt = stat_r;
          out_final_nxt  = 1'b1;
          state_nxt      = S_IDLE;
          cnt_nxt        = '0;
          ovf_nxt        = 1'b0;
        end
      end

      default: begin
        state_nxt = S_IDLE;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      order_r     <= '0;
      par_store_r <= 1'b0;
      idx_r       <= '0;
      dv1_r       <= 1'b0;
      dv2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      order_r     <= order_nxt;
      par_store_r <= par_store_nxt;
      idx_r       <= idx_nxt;
      dv1_r       <= dv1_nxt;
      dv2_r       <= dv2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    i1_r         <= i1_nxt;
    i2_r         <= i2_nxt;
    stat_r       <= stat_nxt;
    out_pos_r    <= out_pos_nxt;
    out_entry_r  <= out_entry_nxt;
    out_inv_r    <= out_inv_nxt;
    out_odd_r    <= out_odd_nxt;
    out_status_r <= out_status_nxt;
    out_final_r  <= out_final_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_position      = out_pos_r;
  assign out_entry_value   = out_entry_r;
  assign out_inverse_value = out_inv_r;
  assign out_odd           = out_odd_r;
  assign out_status        = out_status_r;
  assign out_final_res     = out_final_r;

  // an error item always closes its run
  `PCIP_ASSERT_IMP(a_err_is_final, clk, rst_n, out_valid_r && (out_status_r != ST_OK), out_final_r)
  // parity only shows on the closing item
  `PCIP_ASSERT_IMP(a_odd_on_final, clk, rst_n, out_valid_r && out_odd_r, out_final_r)
  // the closing symbol starts processing, input is held off
  `PCIP_ASSERT_NXT(a_last_stalls, clk, rst_n, in_acc && in_last, in_stall)
  // while results of a run are still due, no symbol is taken
  `PCIP_ASSERT_IMP(a_busy_mid_run, clk, rst_n, out_valid_r && !out_final_r, in_stall)
  // buffered count never passes the limit
  `PCIP_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(ORDER_LIMIT))

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for permutation_compose_inverse_parity: a directed table of symbols, then
// random load and compose runs; each result is checked against a behavioural store model
// or the status given in the directed table. Depends on pcip_pkg and the RTL of the block.
module tb;
  import pcip_pkg::*;

  localparam int ORDER_MAX       = PCIP_ORDER_LIMIT;
  localparam int QUIET_LIMIT     = 5000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 111;
  localparam int TAIL_CYCLES     = 200;
  localparam int IDLE_IN[4]      = '{0, 69, 0, 18};
  localparam int IDLE_OUT[4]     = '{0, 0, 69, 18};

  typedef struct {
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_value;
    logic [POS_W-1:0] inverse_value;
    logic             odd;
    status_t          status;
    logic             final_res;
  } perm_result_t;

  typedef struct {
    logic             cmd;
    logic [SYM_W-1:0] sym;
    logic             is_last;
    bit               typed;
    status_t          want_status;
  } sym_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_command;
  logic [SYM_W-1:0]  in_symbol;
  logic              in_last;
  logic              out_valid;
  logic              out_stall;
  logic [POS_W-1:0]  out_position;
  logic [POS_W-1:0]  out_entry_value;
  logic [POS_W-1:0]  out_inverse_value;
  logic              out_odd;
  logic [STAT_W-1:0] out_status;
  logic              out_final_res;

  // Model of the store
  logic [POS_W-1:0]  perm_q[ORDER_MAX];
  int                perm_order;
  logic [SYM_W-1:0]  pend_sym[ORDER_MAX];
  int                pend_cnt;
  bit                pend_over;

  perm_result_t      due_results[$];
  perm_result_t      fresh[$];
  perm_result_t      want;
  int                fails;
  int                idle_in_pct;
  int                idle_out_pct;
  bit                hold_req;
  int                quiet;
  int                sent;

  always #2 clk = ~clk;

  permutation_compose_inverse_parity DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_symbol         (in_symbol),
    .in_last           (in_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_position      (out_position),
    .out_entry_value   (out_entry_value),
    .out_inverse_value (out_inverse_value),
    .out_odd           (out_odd),
    .out_status        (out_status),
    .out_final_res     (out_final_res)
  );

  // Buffer one symbol; on the last one judge the run and fill fresh with its results
  task automatic judge_symbol(logic cmd, logic [SYM_W-1:0] sym, logic is_last);
    logic [ORDER_MAX-1:0] seen;
    logic [POS_W-1:0]     next_q[ORDER_MAX];
    logic [POS_W-1:0]     inv_q[ORDER_MAX];
    status_t              st;
    int                   n;
    logic                 odd;
    fresh.delete();
    if (pend_cnt < ORDER_MAX) begin
      pend_sym[pend_cnt] = sym;
      pend_cnt++;
    end else begin
      pend_over = 1'b1;
    end
    if (!is_last) return;

    n = pend_cnt;
    st = ST_OK;
    seen = '0;
    // overflow first, then range and duplicate in index order, then missing
    if (pend_over) begin
      st = ST_OVERFLOW;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (st == ST_OK) begin
          if (pend_sym[i] >= n) st = ST_RANGE;
          else if (seen[pend_sym[i][POS_W-1:0]]) st = ST_DUP;
          else seen[pend_sym[i][POS_W-1:0]] = 1'b1;
        end
      end
      for (int i = 0; i < n; i++)
        if (st == ST_OK && !seen[i]) st = ST_MISSING;
    end
    if (st == ST_OK && cmd == CMD_COMPOSE && n != perm_order) st = ST_MISMATCH;
    pend_cnt = 0;
    pend_over = 1'b0;

    if (st != ST_OK) begin
      fresh.push_back('{4'd0, 4'd0, 4'd0, 1'b0, st, 1'b1});
      return;
    end

    // new store, its inverse and the inversion parity
    for (int i = 0; i < n; i++)
      next_q[i] = (cmd == CMD_COMPOSE) ? perm_q[pend_sym[i][POS_W-1:0]]
                                       : pend_sym[i][POS_W-1:0];
    odd = 1'b0;
    for (int i = 0; i < n; i++) begin
      perm_q[i] = next_q[i];
      inv_q[next_q[i]] = i[POS_W-1:0];
      for (int j = i + 1; j < n; j++)
        if (next_q[i] > next_q[j]) odd = ~odd;
    end
    perm_order = n;
    for (int i = 0; i < n; i++)
      fresh.push_back('{i[POS_W-1:0], perm_q[i], inv_q[i], (i == n - 1) ? odd : 1'b0,
                        ST_OK, (i == n - 1)});
  endtask

  // Offer one item, wait for it to be taken, then record what it should produce
  task automatic send_item(logic cmd, logic [SYM_W-1:0] sym, logic is_last, bit typed,
                           status_t want_st);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_in_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_symbol  <= sym;
    in_last    <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    judge_symbol(cmd, sym, is_last);
    if (typed) due_results.push_back('{4'd0, 4'd0, 4'd0, 1'b0, want_st, 1'b1});
    else foreach (fresh[k]) due_results.push_back(fresh[k]);
    sent++;
  endtask

  // One run: mostly well-formed loads and composes, some broken, a few overflowing
  task automatic random_run();
    logic [SYM_W-1:0] seq[$];
    logic [SYM_W-1:0] tmp;
    logic             cmd;
    int               kind;
    int               n;
    int               j;
    kind = $urandom_range(0, 99);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, ORDER_MAX) : $urandom_range(1, 8);
    cmd = CMD_LOAD;
    if (kind >= 45 && kind < 75) begin
      cmd = CMD_COMPOSE;
      if (perm_order > 0 && $urandom_range(0, 9) < 8) n = perm_order;
    end else if (kind >= 75) begin
      cmd = logic'($urandom_range(0, 1));
    end
    if (kind >= 92) n = $urandom_range(ORDER_MAX + 1, ORDER_MAX + 3);

    for (int i = 0; i < n; i++) seq.push_back(i[SYM_W-1:0]);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = seq[i];
      seq[i] = seq[j];
      seq[j] = tmp;
    end
    // broken runs: one corrupted entry or pure noise
    if (kind >= 75 && kind < 92 && $urandom_range(0, 1)) begin
      seq[$urandom_range(0, n - 1)] = SYM_W'($urandom_range(0, 63));
    end else if (kind >= 75) begin
      foreach (seq[i]) seq[i] = SYM_W'($urandom_range(0, 63));
    end

    foreach (seq[i])
      send_item((i == n - 1) ? cmd : logic'($urandom_range(0, 1)), seq[i], i == n - 1,
                1'b0, ST_OK);
  endtask

  task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing expected, position %0d status %0d", $time,
                 out_position, out_status);
        fails++;
      end else begin
        want = due_results.pop_front();
        check_field("position", 8'(want.position), 8'(out_position));
        check_field("entry_value", 8'(want.entry_value), 8'(out_entry_value));
        check_field("inverse_value", 8'(want.inverse_value), 8'(out_inverse_value));
        check_field("odd", 8'(want.odd), 8'(out_odd));
        check_field("status", 8'(want.status), 8'(out_status));
        check_field("final_res", 8'(want.final_res), 8'(out_final_res));
      end
    end
  end

  // Watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < idle_out_pct);
    end
  end

  // Sender and sequencing of phases
  initial begin
    sym_row_t dir_rows[$];
    in_valid     = 1'b0;
    in_command   = CMD_LOAD;
    in_symbol    = '0;
    in_last      = 1'b0;
    rst_n        = 1'b0;
    perm_order   = 0;
    pend_cnt     = 0;
    pend_over    = 1'b0;
    fails        = 0;
    idle_in_pct  = 0;
    idle_out_pct = 0;
    hold_req     = 1'b0;
    sent         = 0;
    foreach (perm_q[i]) perm_q[i] = '0;

    // directed: compose on an empty store, symbol at its top, duplicate, order one,
    // swap then compose with the command only on the last item, overflow
    dir_rows.push_back('{CMD_COMPOSE, 6'd0, 1'b1, 1'b1, ST_MISMATCH});
    dir_rows.push_back('{CMD_LOAD, 6'd63, 1'b1, 1'b1, ST_RANGE});
    dir_rows.push_back('{CMD_LOAD, 6'd0, 1'b0, 1'b0, ST_OK});
    dir_rows.push_back('{CMD_LOAD, 6'd0, 1'b1, 1'b1, ST_DUP});
    dir_rows.push_back('{CMD_LOAD, 6'd0, 1'b1, 1'b1, ST_OK});
    dir_rows.push_back('{CMD_LOAD, 6'd1, 1'b0, 1'b0, ST_OK});
    dir_rows.push_back('{CMD_LOAD, 6'd0, 1'b1, 1'b0, ST_OK});
    dir_rows.push_back('{CMD_LOAD, 6'd1, 1'b0, 1'b0, ST_OK});
    dir_rows.push_back('{CMD_COMPOSE, 6'd0, 1'b1, 1'b0, ST_OK});
    for (int i = 0; i < ORDER_MAX; i++)
      dir_rows.push_back('{CMD_LOAD, i[SYM_W-1:0], 1'b0, 1'b0, ST_OK});
    dir_rows.push_back('{CMD_LOAD, 6'd63, 1'b1, 1'b1, ST_OVERFLOW});

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].sym, dir_rows[i].is_last, dir_rows[i].typed,
                dir_rows[i].want_status);

    // random phases; the first opens with a long receiver hold-off
    for (int phase = 0; phase < 4; phase++) begin
      idle_in_pct  = IDLE_IN[phase];
      idle_out_pct = IDLE_OUT[phase];
      if (phase == 0) hold_req = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) random_run();
      @(negedge clk);
      in_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clk);
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== permutation_compose_inverse_parity.f =====
+incdir+design
design/pcip_pkg.sv
design/pcip_mem.sv
design/pcip_check.sv
design/permutation_compose_inverse_parity.sv
tb/tb.sv
